/* sv/dergate_pkg.sv */
// ----------------------------------------------------------------------------
// dergate_pkg
// Widths, register indexes, state codes and the command and status bundles
// shared by the dual moving-average rise gate.
// ----------------------------------------------------------------------------
package dergate_pkg;

   localparam int ALPHA_W    = 16;
   localparam int CAP_W      = 17;
   localparam int FLOOR_W    = 31;
   localparam int TICK_W     = 32;
   localparam int GATE_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_STEPS  = GATE_W;
   localparam int CNT_W      = 5;

   localparam logic [GATE_W-1:0]  GATE_MAX   = 17'h1FFFF;
   localparam logic [ALPHA_W-1:0] ROUND_HALF = 16'h8000;

   localparam logic [ALPHA_W-1:0] ALPHA_SHORT_RST = 16'd6554;
   localparam logic [ALPHA_W-1:0] ALPHA_LONG_RST  = 16'd66;
   localparam logic [CAP_W-1:0]   CAP_RST         = 17'd32768;
   localparam logic               ENABLED_RST     = 1'b1;
   localparam logic [FLOOR_W-1:0] FLOOR_RST       = 31'd66;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_SHORT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LONG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_FLOOR  = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EMA_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_EMA_UPD,
      ST_DIV_INIT,
      ST_DIV_CHECK,
      ST_DIV_STEP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_first;
      logic sel;
      logic ema_diff;
      logic mul_lo;
      logic mul_hi;
      logic ema_upd;
      logic div_init;
      logic div_check;
      logic div_step;
      logic div_first;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic op_tick;
      logic averages_ready;
      logic rsp_free;
   } status_type;

endpackage

/* sv/dergate_if.sv */
// ----------------------------------------------------------------------------
// dergate channel interfaces
// Request, response and register-write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface dergate_req_if #(parameter int SAMPLE_BITS = 16);
   logic                               valid;
   logic                               ready;
   logic                               op;
   logic signed [SAMPLE_BITS-1:0]      sample;
   logic [dergate_pkg::TICK_W-1:0]     tick_id;

   modport source (output valid, op, sample, tick_id, input ready);
   modport sink   (input valid, op, sample, tick_id, output ready);
endinterface

interface dergate_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dergate_pkg::TICK_W-1:0]     tick_id_out;
   logic [dergate_pkg::GATE_W-1:0]     gate_value;
   logic                               gate_active;

   modport source (output valid, tick_id_out, gate_value, gate_active, input ready);
   modport sink   (input valid, tick_id_out, gate_value, gate_active, output ready);
endinterface

interface dergate_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dergate_pkg::CSR_IDX_W-1:0]  index;
   logic [dergate_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/dergate_ctrl.sv */
// ----------------------------------------------------------------------------
// dergate_ctrl
// Sequencer: decodes a beat, steps the shared multiplier through both
// averages and runs the seventeen divider iterations of a tick.
// ----------------------------------------------------------------------------
module dergate_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dergate_pkg::status_type sts,
   output dergate_pkg::cmd_type    cmd
);
   import dergate_pkg::*;

   state_type          state_ff, state_in;
   logic               sel_ff, sel_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               last_step;

   assign last_step = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (sts.op_tick) begin
               state_in = ST_DIV_INIT;
            end else if (!sts.averages_ready) begin
               state_in = ST_IDLE;
            end else begin
               sel_in   = 1'b0;
               state_in = ST_EMA_DIFF;
            end
         end
         ST_EMA_DIFF: state_in = ST_MUL_LO;
         ST_MUL_LO:   state_in = ST_MUL_HI;
         ST_MUL_HI:   state_in = ST_EMA_UPD;
         ST_EMA_UPD: begin
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_EMA_DIFF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV_CHECK;
         ST_DIV_CHECK: begin
            cnt_in   = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (last_step) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.sel   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = !reset;
            cmd.capture = req_valid && !reset;
         end
         ST_DECODE:    cmd.load_first = !sts.op_tick && !sts.averages_ready;
         ST_EMA_DIFF:  cmd.ema_diff   = 1'b1;
         ST_MUL_LO:    cmd.mul_lo     = 1'b1;
         ST_MUL_HI:    cmd.mul_hi     = 1'b1;
         ST_EMA_UPD:   cmd.ema_upd    = 1'b1;
         ST_DIV_INIT:  cmd.div_init   = 1'b1;
         ST_DIV_CHECK: cmd.div_check  = 1'b1;
         ST_DIV_STEP: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (cnt_ff == '0);
         end
         ST_OUT:       cmd.rsp_load   = sts.rsp_free;
         default:      cmd            = '0;
      endcase
   end

endmodule

/* sv/dergate_dp.sv */
// ----------------------------------------------------------------------------
// dergate_dp
// Datapath: register file, the two moving averages with a shared split
// multiplier, a restoring divider for the rise ratio and the result register.
// ----------------------------------------------------------------------------
module dergate_dp #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dergate_pkg::cmd_type                cmd,
   output dergate_pkg::status_type             sts,
   input  logic                                req_op,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic [dergate_pkg::TICK_W-1:0]      req_tick_id,
   input  logic                                csr_write,
   input  logic [dergate_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dergate_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dergate_pkg::TICK_W-1:0]      rsp_tick_id_out,
   output logic [dergate_pkg::GATE_W-1:0]      rsp_gate_value,
   output logic                                rsp_gate_active
);
   import dergate_pkg::*;

   localparam int AW  = SAMPLE_BITS + FRACTION_BITS;
   localparam int H   = (AW + 1) / 2;
   localparam int PLW = ALPHA_W + H;
   localparam int PHW = ALPHA_W + AW - H;
   localparam int PW  = ALPHA_W + AW;
   localparam int CW  = (AW > FLOOR_W + 1) ? AW : FLOOR_W + 1;

   logic [ALPHA_W-1:0]         alpha_short_ff, alpha_long_ff;
   logic [CAP_W-1:0]           cap_ff;
   logic                       enabled_ff;
   logic [FLOOR_W-1:0]         floor_ff;

   logic                       op_ff;
   logic [SAMPLE_BITS-1:0]     sample_ff;
   logic [TICK_W-1:0]          tick_ff;

   logic                       ready_ff;
   logic [AW-1:0]              short_ff, long_ff;

   logic                       neg_ff;
   logic [AW-1:0]              mag_ff;
   logic [PLW-1:0]             prod_ff;
   logic [PW-1:0]              acc_ff;

   logic [AW:0]                rem_ff, rem_in;
   logic [GATE_W-1:0]          quo_ff;
   logic                       off_ff, nonpos_ff, sat_ff;

   logic                       rsp_valid_ff;
   logic [TICK_W-1:0]          rsp_tick_ff;
   logic [GATE_W-1:0]          rsp_value_ff;
   logic                       rsp_active_ff;

   logic [AW-1:0]              x_val, avg_sel, avg_in;
   logic [AW:0]                diff_w, mag_full, upd_full;
   logic [ALPHA_W-1:0]         alpha_sel;
   logic [PLW-1:0]             prod_in;
   logic [PW-1:0]              sum_w;
   logic [AW-1:0]              step_w;
   logic [AW:0]                cand, den;
   logic                       ge;
   logic                       off_in;
   logic [GATE_W-1:0]          ratio, clamped;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_short_ff <= ALPHA_SHORT_RST;
         alpha_long_ff  <= ALPHA_LONG_RST;
         cap_ff         <= CAP_RST;
         enabled_ff     <= ENABLED_RST;
         floor_ff       <= FLOOR_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ALPHA_SHORT: alpha_short_ff <= csr_data[ALPHA_W-1:0];
            CSR_ALPHA_LONG:  alpha_long_ff  <= csr_data[ALPHA_W-1:0];
            CSR_CAP:         cap_ff         <= csr_data[CAP_W-1:0];
            CSR_ENABLED:     enabled_ff     <= csr_data[0];
            CSR_LONG_FLOOR:  floor_ff       <= csr_data[FLOOR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         sample_ff <= req_sample;
         tick_ff   <= req_tick_id;
      end
   end

   // moving averages
   assign x_val     = {sample_ff, {FRACTION_BITS{1'b0}}};
   assign avg_sel   = cmd.sel ? long_ff : short_ff;
   assign alpha_sel = cmd.sel ? alpha_long_ff : alpha_short_ff;
   assign diff_w    = {x_val[AW-1], x_val} - {avg_sel[AW-1], avg_sel};
   assign mag_full  = diff_w[AW] ? ((AW+1)'(0) - diff_w) : diff_w;

   assign prod_in = cmd.mul_lo ? PLW'(alpha_sel) * PLW'(mag_ff[H-1:0])
                               : PLW'(alpha_sel) * PLW'(mag_ff[AW-1:H]);

   assign sum_w    = acc_ff + {prod_ff[PHW-1:0], {H{1'b0}}};
   assign step_w   = sum_w[PW-1:ALPHA_W];
   assign upd_full = neg_ff ? ({avg_sel[AW-1], avg_sel} - {1'b0, step_w})
                            : ({avg_sel[AW-1], avg_sel} + {1'b0, step_w});
   assign avg_in   = upd_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.ema_diff) begin
         neg_ff <= diff_w[AW];
         mag_ff <= mag_full[AW-1:0];
      end
      if (cmd.mul_lo || cmd.mul_hi) prod_ff <= prod_in;
      if (cmd.mul_hi) acc_ff <= PW'(prod_ff) + PW'(ROUND_HALF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         short_ff <= '0;
         long_ff  <= '0;
      end else if (cmd.load_first) begin
         ready_ff <= 1'b1;
         short_ff <= x_val;
         long_ff  <= x_val;
      end else if (cmd.ema_upd) begin
         if (cmd.sel) long_ff  <= avg_in;
         else         short_ff <= avg_in;
      end
   end

   // rise ratio divider
   assign off_in = !enabled_ff || !ready_ff ||
                   ($signed({{(CW-AW){long_ff[AW-1]}}, long_ff}) <=
                    $signed({{(CW-FLOOR_W){1'b0}}, floor_ff}));
   assign den    = {1'b0, long_ff};
   assign cand   = cmd.div_first ? rem_ff : {rem_ff[AW-1:0], 1'b0};
   assign ge     = (cand >= den);

   always_comb begin
      rem_in = rem_ff;
      if (cmd.div_init)      rem_in = {short_ff[AW-1], short_ff} - {long_ff[AW-1], long_ff};
      else if (cmd.div_step) rem_in = ge ? (cand - den) : cand;
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (cmd.div_init) off_ff <= off_in;
      if (cmd.div_check) begin
         nonpos_ff <= rem_ff[AW] || (rem_ff == '0);
         sat_ff    <= ($signed(rem_ff) >= $signed({long_ff, 1'b0}));
      end
      if (cmd.div_step) quo_ff <= {quo_ff[GATE_W-2:0], ge};
   end

   // result register
   assign ratio   = nonpos_ff ? '0 : (sat_ff ? GATE_MAX : quo_ff);
   assign clamped = (ratio > cap_ff) ? cap_ff : ratio;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_tick_ff   <= tick_ff;
         rsp_value_ff  <= off_ff ? '0 : clamped;
         rsp_active_ff <= !off_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tick_id_out = rsp_tick_ff;
   assign rsp_gate_value  = rsp_value_ff;
   assign rsp_gate_active = rsp_active_ff;

   assign sts.op_tick        = (op_ff == OP_TICK);
   assign sts.averages_ready = ready_ff;
   assign sts.rsp_free       = !rsp_valid_ff || rsp_ready;

endmodule

/* sv/dual_ema_rise_gate_unit.sv */
// ----------------------------------------------------------------------------
// dual_ema_rise_gate_unit
// Short/long moving-average relative rise gate, top level.
// ----------------------------------------------------------------------------
// req_bus carries one beat per operation: op selects a sample update or a
// tick request. A sample update returns nothing; a tick returns one beat on
// rsp_bus with the tick label, the gate value (Q1.16) and the active flag.
// csr_bus writes the five registers by index and is always ready outside
// reset; write it only while the block is idle.
// The first sample after reset loads both averages directly; a later sample
// updates two averages, four steps each through one 16 x (width/2)
// multiplier. A tick runs divider set-up, the 17 iterations of the restoring
// divider and the result load before rsp_bus goes valid.
// One operation is in flight at a time; req_bus ready returns once the
// previous one has finished.
// Reset clears the averages and their ready flag and reloads the register
// defaults. A finished result waits in the output register while rsp_bus is
// stalled; the next beat is still taken, and a following tick holds in its
// final step until the output register frees.
// ----------------------------------------------------------------------------
module dual_ema_rise_gate_unit #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   dergate_req_if.sink   req_bus,
   dergate_rsp_if.source rsp_bus,
   dergate_csr_if.sink   csr_bus
);
   import dergate_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_bus.ready = !reset;

   dergate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dergate_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_bus.op),
      .req_sample      (req_bus.sample),
      .req_tick_id     (req_bus.tick_id),
      .csr_write       (csr_bus.valid && !reset),
      .csr_index       (csr_bus.index),
      .csr_data        (csr_bus.data),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_tick_id_out (rsp_bus.tick_id_out),
      .rsp_gate_value  (rsp_bus.gate_value),
      .rsp_gate_active (rsp_bus.gate_active)
   );

endmodule

/* sv/dergate_chk.sv */
// ----------------------------------------------------------------------------
// dergate_chk
// Port-level checks on the rise gate, bound to the top level.
// ----------------------------------------------------------------------------
module dergate_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [dergate_pkg::TICK_W-1:0]     rsp_tick_id_out,
   input logic [dergate_pkg::GATE_W-1:0]     rsp_gate_value,
   input logic                               rsp_gate_active
);
   import dergate_pkg::*;

   a_reset_drops_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tick_id_out) &&
                                  $stable(rsp_gate_value) && $stable(rsp_gate_active))
      else $error("stalled result beat changed");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gate_active |-> rsp_gate_value == '0)
      else $error("inactive gate with non-zero value");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

endmodule

bind dual_ema_rise_gate_unit dergate_chk u_dergate_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_tick_id_out (rsp_bus.tick_id_out),
   .rsp_gate_value  (rsp_bus.gate_value),
   .rsp_gate_active (rsp_bus.gate_active)
);

/* tb/dergate_checker.sv */
// ----------------------------------------------------------------------------
// dergate_checker
// Watches the request, response and register channels of the dual moving-
// average rise gate, keeps its own copy of the averages and registers, works
// out the gate result of every accepted tick and compares each response beat
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module dergate_checker #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_op,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic [dergate_pkg::TICK_W-1:0]      req_tick_id,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [dergate_pkg::TICK_W-1:0]      rsp_tick_id_out,
   input  logic [dergate_pkg::GATE_W-1:0]      rsp_gate_value,
   input  logic                                rsp_gate_active,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [dergate_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dergate_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                  gate_pending,
   output int                                  gate_errors,
   output int                                  beat_count,
   output int                                  samples_seen,
   output int                                  gates_checked,
   output int                                  gates_active
);

   timeunit 1ns;
   timeprecision 1ps;

   import dergate_pkg::*;

   typedef struct packed {
      logic [TICK_W-1:0] tick_id;
      logic [GATE_W-1:0] value;
      logic              active;
   } gate_beat_type;

   logic [ALPHA_W-1:0] weight_short;
   logic [ALPHA_W-1:0] weight_long;
   logic [CAP_W-1:0]   gate_cap;
   logic               gate_on;
   logic [FLOOR_W-1:0] warm_floor;

   logic   averages_primed;
   longint short_avg;
   longint long_avg;

   gate_beat_type expected_gates[$];

   function automatic longint ema_move(longint avg, longint target, logic [ALPHA_W-1:0] weight);
      longint          delta;
      longint unsigned mag;
      longint unsigned w;
      longint unsigned step;
      delta = target - avg;
      mag   = (delta < 0) ? longint'(-delta) : longint'(delta);
      w     = longint'(weight);
      step  = w * (mag >> ALPHA_W)
            + ((w * (mag & longint'(GATE_MAX >> 1)) + longint'(ROUND_HALF)) >> ALPHA_W);
      return (delta < 0) ? avg - longint'(step) : avg + longint'(step);
   endfunction

   function automatic gate_beat_type rise_gate(logic [TICK_W-1:0] id);
      gate_beat_type   beat;
      longint unsigned diff;
      longint unsigned den;
      longint unsigned quo;
      longint unsigned rem;
      longint unsigned ratio;
      beat.tick_id = id;
      beat.value   = '0;
      beat.active  = 1'b0;
      if (!gate_on || !averages_primed || long_avg <= longint'(warm_floor)) return beat;
      ratio = 0;
      if (short_avg > long_avg) begin
         diff = longint'(short_avg - long_avg);
         den  = longint'(long_avg);
         quo  = diff / den;
         rem  = diff % den;
         if (quo >= 2) ratio = longint'(GATE_MAX);
         else ratio = (quo << ALPHA_W) + (rem << ALPHA_W) / den;
         if (ratio > longint'(GATE_MAX)) ratio = longint'(GATE_MAX);
      end
      if (ratio > longint'(gate_cap)) ratio = longint'(gate_cap);
      beat.value  = GATE_W'(ratio);
      beat.active = 1'b1;
      return beat;
   endfunction

   always @(posedge clock) begin
      gate_beat_type want;
      longint        target;
      if (reset) begin
         weight_short    = ALPHA_SHORT_RST;
         weight_long     = ALPHA_LONG_RST;
         gate_cap        = CAP_RST;
         gate_on         = ENABLED_RST;
         warm_floor      = FLOOR_RST;
         averages_primed = 1'b0;
         short_avg       = 0;
         long_avg        = 0;
         expected_gates.delete();
         gate_errors     = 0;
         beat_count      = 0;
         samples_seen    = 0;
         gates_checked   = 0;
         gates_active    = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beat_count++;
            gates_checked++;
            if (rsp_gate_active) gates_active++;
            if (expected_gates.size() == 0) begin
               gate_errors++;
               $display("%0t: gate beat with none expected, actual tick %h value %0d active %b",
                        $time, rsp_tick_id_out, rsp_gate_value, rsp_gate_active);
            end else begin
               want = expected_gates.pop_front();
               if (rsp_tick_id_out !== want.tick_id) begin
                  gate_errors++;
                  $display("%0t: tick_id_out expected %h actual %h",
                           $time, want.tick_id, rsp_tick_id_out);
               end
               if (rsp_gate_value !== want.value) begin
                  gate_errors++;
                  $display("%0t: tick %h gate_value expected %0d actual %0d",
                           $time, want.tick_id, want.value, rsp_gate_value);
               end
               if (rsp_gate_active !== want.active) begin
                  gate_errors++;
                  $display("%0t: tick %h gate_active expected %b actual %b",
                           $time, want.tick_id, want.active, rsp_gate_active);
               end
            end
         end
         if (req_valid && req_ready) begin
            beat_count++;
            if (req_op == OP_TICK) begin
               expected_gates.insert(expected_gates.size(), rise_gate(req_tick_id));
            end else begin
               samples_seen++;
               target = longint'(req_sample) * (longint'(1) << FRACTION_BITS);
               if (!averages_primed) begin
                  short_avg       = target;
                  long_avg        = target;
                  averages_primed = 1'b1;
               end else begin
                  short_avg = ema_move(short_avg, target, weight_short);
                  long_avg  = ema_move(long_avg, target, weight_long);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            beat_count++;
            case (csr_index)
               CSR_ALPHA_SHORT: weight_short = csr_data[ALPHA_W-1:0];
               CSR_ALPHA_LONG:  weight_long  = csr_data[ALPHA_W-1:0];
               CSR_CAP:         gate_cap     = csr_data[CAP_W-1:0];
               CSR_ENABLED:     gate_on      = csr_data[0];
               CSR_LONG_FLOOR:  warm_floor   = csr_data[FLOOR_W-1:0];
               default: ;
            endcase
         end
      end
      gate_pending = expected_gates.size();
   end

endmodule

/* tb/tb_dual_ema_rise_gate_unit.sv */
// ----------------------------------------------------------------------------
// tb_dual_ema_rise_gate_unit
// Drives samples, ticks and register writes into the rise gate with random
// gaps and receiver stalls, one long receiver hold-off to back the block up,
// and a set of register settings from the extremes to random ones. Checking
// is done by dergate_checker; this module only stimulates and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_dual_ema_rise_gate_unit;

   timeunit 1ns;
   timeprecision 1ps;

   import dergate_pkg::*;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 72;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SAMPLE_MAX    = 32767;
   localparam int SAMPLE_MIN    = -32768;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic clock;
   logic reset;

   int gate_pending;
   int gate_errors;
   int beat_count;
   int samples_seen;
   int gates_checked;
   int gates_active;

   int settings_count = 0;
   bit req_free_run   = 1'b0;
   bit rsp_free_run   = 1'b0;
   bit rsp_hold_req   = 1'b0;

   dergate_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   dergate_rsp_if                              rsp_bus ();
   dergate_csr_if                              csr_bus ();

   dual_ema_rise_gate_unit #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   dergate_checker #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_op         (req_bus.op),
      .req_sample     (req_bus.sample),
      .req_tick_id    (req_bus.tick_id),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_tick_id_out(rsp_bus.tick_id_out),
      .rsp_gate_value (rsp_bus.gate_value),
      .rsp_gate_active(rsp_bus.gate_active),
      .csr_valid      (csr_bus.valid),
      .csr_ready      (csr_bus.ready),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .gate_pending   (gate_pending),
      .gate_errors    (gate_errors),
      .beat_count     (beat_count),
      .samples_seen   (samples_seen),
      .gates_checked  (gates_checked),
      .gates_active   (gates_active)
   );

   always #4 clock = ~clock;

   function automatic int pick_gap(bit free_run);
      int roll;
      if (free_run) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int next_sample(int level);
      int roll;
      int value;
      roll = $urandom_range(0, 99);
      if (roll < 70) value = level + int'($urandom_range(0, 100)) - 50;
      else if (roll < 85) value = level + int'($urandom_range(0, 8000));
      else if (roll < 93) value = level - int'($urandom_range(0, 4000));
      else value = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
      if (value > SAMPLE_MAX) value = SAMPLE_MAX;
      if (value < SAMPLE_MIN) value = SAMPLE_MIN;
      return value;
   endfunction

   task automatic send_op(logic op, logic [SAMPLE_BITS-1:0] sample, logic [TICK_W-1:0] tick);
      int gap;
      req_bus.op      <= op;
      req_bus.sample  <= sample;
      req_bus.tick_id <= tick;
      req_bus.valid   <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      gap = pick_gap(req_free_run);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic sample_beat(int value);
      send_op(OP_SAMPLE, SAMPLE_BITS'(value), TICK_W'($urandom));
   endtask

   task automatic tick_beat(logic [TICK_W-1:0] id);
      send_op(OP_TICK, SAMPLE_BITS'($urandom), id);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (gate_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.index <= index;
      csr_bus.data  <= data;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_gate(logic [ALPHA_W-1:0] a_short, logic [ALPHA_W-1:0] a_long,
                               logic [CAP_W-1:0] cap, logic enabled,
                               logic [FLOOR_W-1:0] floor_q16);
      settle();
      write_reg(CSR_ALPHA_SHORT, {16'($urandom), a_short});
      write_reg(CSR_ALPHA_LONG, {16'($urandom), a_long});
      write_reg(CSR_CAP, {15'($urandom), cap});
      write_reg(CSR_ENABLED, {31'($urandom), enabled});
      write_reg(CSR_LONG_FLOOR, {1'($urandom), floor_q16});
      write_reg(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom);
      settings_count++;
   endtask

   // receiver: random stalls, free-running stretches and one long hold-off
   initial begin
      int hold_left;
      int stall_left;
      bit hold_used;
      hold_left     = 0;
      stall_left    = 0;
      hold_used     = 1'b0;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_hold_req && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(rsp_free_run);
         end
      end
   end

   // watchdog: too many cycles without any beat on any channel
   initial begin
      int idle_cycles;
      int last_beats;
      idle_cycles = 0;
      last_beats  = 0;
      forever begin
         @(negedge clock);
         if (reset || beat_count != last_beats) begin
            last_beats  = beat_count;
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d gates outstanding",
                     idle_cycles, gate_pending);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [ALPHA_W-1:0] a_short;
      logic [ALPHA_W-1:0] a_long;
      logic [CAP_W-1:0]   cap;
      logic               enabled;
      logic [FLOOR_W-1:0] floor_q16;
      int                 level;
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_SAMPLE;
      req_bus.sample  = '0;
      req_bus.tick_id = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_ALPHA_SHORT;
      csr_bus.data    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: not primed, first load, saturation, kill switch, floor, alpha extremes
      tick_beat(32'h0000_0000);
      sample_beat(1);
      tick_beat(32'hFFFF_FFFF);
      sample_beat(SAMPLE_MAX);
      tick_beat($urandom);
      sample_beat(SAMPLE_MIN);
      tick_beat($urandom);
      program_gate(ALPHA_SHORT_RST, ALPHA_LONG_RST, CAP_RST, 1'b0, FLOOR_RST);
      tick_beat($urandom);
      program_gate(16'd0, 16'hFFFF, 17'd65536, 1'b1, 31'h7FFF_FFFF);
      sample_beat(SAMPLE_MAX);
      tick_beat($urandom);
      program_gate(16'hFFFF, 16'hFFFF, 17'd65536, 1'b1, 31'd0);
      sample_beat(SAMPLE_MIN);
      tick_beat($urandom);
      sample_beat(2);
      tick_beat($urandom);
      program_gate(16'hFFFF, 16'd0, 17'h1FFFF, 1'b1, 31'd0);
      sample_beat(SAMPLE_MAX);
      tick_beat($urandom);
      sample_beat(3);
      tick_beat($urandom);
      program_gate(16'hFFFF, 16'd0, 17'd0, 1'b1, 31'd0);
      sample_beat(5);
      tick_beat($urandom);

      // random phases, one register setting each
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0:       a_short = '0;
            1:       a_short = '1;
            default: a_short = ALPHA_W'($urandom_range(2000, 40000));
         endcase
         case ($urandom_range(0, 5))
            0:       a_long = '0;
            1:       a_long = '1;
            default: a_long = ALPHA_W'($urandom_range(1, 4000));
         endcase
         case ($urandom_range(0, 5))
            0:       cap = '0;
            1:       cap = 17'd65536;
            2:       cap = '1;
            default: cap = CAP_W'($urandom_range(1, 131071));
         endcase
         enabled = ($urandom_range(0, 7) != 0);
         case ($urandom_range(0, 7))
            0:       floor_q16 = '0;
            1:       floor_q16 = '1;
            2:       floor_q16 = FLOOR_W'($urandom);
            3:       floor_q16 = FLOOR_RST;
            default: floor_q16 = FLOOR_W'($urandom_range(0, 1 << 20));
         endcase
         if (phase == PHASES - 1) begin
            a_short   = '1;
            a_long    = '0;
            cap       = '1;
            enabled   = 1'b1;
            floor_q16 = '0;
         end
         program_gate(a_short, a_long, cap, enabled, floor_q16);
         req_free_run = (phase == 0);
         rsp_free_run = (phase == 0);
         if (phase == 2) rsp_hold_req = 1'b1;
         level = $urandom_range(200, 3000);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               if ($urandom_range(0, 3) == 0) level = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
               else level = $urandom_range(200, 3000);
            end
            if ($urandom_range(0, 9) < 4) tick_beat($urandom);
            else sample_beat(next_sample(level));
         end
      end
      req_free_run = 1'b0;
      rsp_free_run = 1'b0;

      settle();
      $display("Run covered %0d samples and %0d ticks (%0d gates active)",
               samples_seen, gates_checked, gates_active);
      $display("over %0d register settings, with random stalls and one long hold-off.",
               settings_count);
      if (gate_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/dergate_pkg.sv
sv/dergate_if.sv
sv/dergate_ctrl.sv
sv/dergate_dp.sv
sv/dual_ema_rise_gate_unit.sv
sv/dergate_chk.sv
tb/dergate_checker.sv
tb/tb_dual_ema_rise_gate_unit.sv
